// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the key-value table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// Key-value table package
// Sizes, request and status codes, and the cell write control type.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // Table geometry.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 32;

    // Request codes.
    localparam logic [1:0] REQ_PUT    = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Write control for one cell.
    typedef struct packed {
        logic               we_key;
        logic               we_value;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } cell_wr_t;

endpackage

// File: rtl/linear_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// Linear key-value table unit
// Each request is captured together with its key compare, then applied in the update state;
// no new request is taken until the update is done, and a waiting result stalls the update.
// Reset clears the entry count and control state; cells stay undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_key_value_table_unit
    import lkv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [KEY_W-1:0]   key,
    input  logic [31:0]        value,
    input  logic [3:0]         index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        result_value,
    output logic [63:0]        result_key,
    output logic               hit,
    output logic [1:0]         status,
    output logic [4:0]         entry_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [1:0]          req_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [3:0]          index_reg;
    logic [CAPACITY-1:0] match_reg;

    logic                out_valid_reg, out_valid_next;
    logic [31:0]         rvalue_reg;
    logic [63:0]         rkey_reg;
    logic                hit_reg;
    logic [1:0]          status_reg;

    logic [31:0]         rvalue_next;
    logic [63:0]         rkey_next;
    logic                hit_next;
    logic [1:0]          status_next;

    logic                accept;
    logic                upd_go;
    logic [CAPACITY-1:0] match;

    cell_wr_t            cell_wr    [CAPACITY];
    logic [KEY_W-1:0]    cell_key   [CAPACITY];
    logic [VALUE_W-1:0]  cell_value [CAPACITY];

    // Row of entry cells.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        lkv_cell u_cell
        (
            .clk     (clk),
            .wr      (cell_wr[g]),
            .cmp_key (key),
            .key     (cell_key[g]),
            .value   (cell_value[g]),
            .match   (match[g])
        );
    end

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign upd_go   = (state_reg == ST_UPD) && (!out_valid_reg || out_ready);

    // Request capture; a put of zero is turned into a remove here.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (req_type == REQ_PUT && value[VALUE_W-1:0] == '0)
            begin
                req_reg <= REQ_REMOVE;
            end
            else
            begin
                req_reg <= req_type;
            end
            key_reg   <= key;
            value_reg <= value[VALUE_W-1:0];
            index_reg <= index;
            for (int i = 0; i < CAPACITY; i++)
            begin
                match_reg[i] <= match[i] && (COUNT_W'(i) < count_reg);
            end
        end
    end

    // Selection of the matched, last and indexed entries, and cell writes.
    always_comb
    begin
        logic [VALUE_W-1:0] found_value;
        logic [KEY_W-1:0]   last_key;
        logic [VALUE_W-1:0] last_value;
        logic [KEY_W-1:0]   idx_key;
        logic [VALUE_W-1:0] idx_value;
        logic               found;
        logic               full;
        logic               idx_ok;
        logic [COUNT_W-1:0] last_pos;
        logic [COUNT_W-1:0] idx_ext;

        found_value = '0;
        last_key    = '0;
        last_value  = '0;
        idx_key     = '0;
        idx_value   = '0;
        found       = |match_reg;
        full        = (count_reg >= COUNT_W'(CAPACITY));
        last_pos    = count_reg - COUNT_W'(1);
        idx_ext     = COUNT_W'(index_reg);
        idx_ok      = (idx_ext < count_reg);

        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_reg[i])
            begin
                found_value = found_value | cell_value[i];
            end
            if (COUNT_W'(i) == last_pos)
            begin
                last_key   = last_key | cell_key[i];
                last_value = last_value | cell_value[i];
            end
            if (COUNT_W'(i) == idx_ext)
            begin
                idx_key   = idx_key | cell_key[i];
                idx_value = idx_value | cell_value[i];
            end
        end

        count_next = count_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_wr[i] = '{we_key: 1'b0, we_value: 1'b0, key: key_reg, value: value_reg};
        end

        // Result fields, held in the output register at the update.
        rvalue_next  = '0;
        rkey_next    = '0;
        hit_next     = 1'b0;
        status_next  = STATUS_OK;

        if (upd_go)
        begin
            out_valid_next = 1'b1;
            unique case (req_reg)
                REQ_PUT:
                begin
                    if (found)
                    begin
                        rvalue_next = found_value;
                        hit_next    = 1'b1;
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            cell_wr[i].we_value = match_reg[i];
                        end
                    end
                    else if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            cell_wr[i].we_key   = (COUNT_W'(i) == count_reg);
                            cell_wr[i].we_value = (COUNT_W'(i) == count_reg);
                        end
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                REQ_GET:
                begin
                    rvalue_next = found_value;
                    hit_next    = found;
                end
                REQ_REMOVE:
                begin
                    rvalue_next = found_value;
                    hit_next    = found;
                    if (found)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            cell_wr[i].we_key   = match_reg[i];
                            cell_wr[i].we_value = match_reg[i];
                            cell_wr[i].key      = last_key;
                            cell_wr[i].value    = last_value;
                        end
                        count_next = last_pos;
                    end
                end
                REQ_READ:
                begin
                    if (idx_ok)
                    begin
                        rkey_next   = idx_key;
                        rvalue_next = idx_value;
                        hit_next    = 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_RANGE;
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    // Sequencer: capture, then update once the output register is free.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            rvalue_reg <= rvalue_next;
            rkey_reg   <= rkey_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = rvalue_reg;
    assign result_key   = rkey_reg;
    assign hit          = hit_reg;
    assign status       = status_reg;
    assign entry_count  = 5'(count_reg);

    // Checks on the sequencer and the entry count.
    `ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_reg <= COUNT_W'(CAPACITY))
    `ASSERT_NEXT(a_accept_to_upd, clk, rst_n, accept, state_reg == ST_UPD)
    `ASSERT_IMPLY(a_full_status, clk, rst_n, out_valid_reg && status_reg == STATUS_FULL,
        count_reg == COUNT_W'(CAPACITY))
    `ASSERT_NEXT(a_count_hold, clk, rst_n, !upd_go, $stable(count_reg))

endmodule

// File: rtl/lkv_cell.sv
// ----------------------------------------------------------------------------
// Key-value table cell
// Holds one entry and compares its key against the broadcast search key.
// ----------------------------------------------------------------------------
module lkv_cell
    import lkv_pkg::*;
(
    input  logic               clk,
    input  cell_wr_t           wr,
    input  logic [KEY_W-1:0]   cmp_key,
    output logic [KEY_W-1:0]   key,
    output logic [VALUE_W-1:0] value,
    output logic               match
);

    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;

    // Entry storage; the contents are undefined until first written.
    always_ff @(posedge clk)
    begin
        if (wr.we_key)
        begin
            key_reg <= wr.key;
        end
        if (wr.we_value)
        begin
            value_reg <= wr.value;
        end
    end

    // Key comparison against the incoming request.
    assign match = (key_reg == cmp_key);
    assign key   = key_reg;
    assign value = value_reg;

endmodule
